[design/csots_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csots_pkg;

  localparam int MAX_WAYS_DEF = 8;
  localparam int TAG_W        = 32;
  localparam int WAYS_W       = 4;
  localparam logic [WAYS_W-1:0] WAYS_RST = WAYS_W'(8);

  typedef enum logic [1:0] {
    REQ_ADD        = 2'd0,
    REQ_ERASE      = 2'd1,
    REQ_LOOKUP     = 2'd2,
    REQ_MARK_DIRTY = 2'd3
  } req_t;

  // one stored way
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             dirty;
    logic             valid;
  } entry_t;

  // per-cell update strobes
  typedef struct packed {
    logic load_prev;
    logic load_next;
    logic set_dirty;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/csots_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module csots_cell
  import csots_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  entry_t           prev_entry,
  input  entry_t           next_entry,
  input  logic [TAG_W-1:0] tag_in,
  input  logic             hit_before,
  output entry_t           entry,
  output logic             match,
  output logic             hit_through
);

  logic [TAG_W-1:0] slot_tag;
  logic             slot_dirty;
  logic             slot_valid;

  assign entry       = '{tag: slot_tag, dirty: slot_dirty, valid: slot_valid};
  assign match       = slot_valid && (slot_tag == tag_in);
  assign hit_through = hit_before | match;

  // valid and dirty cleared at reset, tag left undefined
  always_ff @(posedge clk) begin
    if (ctrl.load_prev) begin
      slot_tag <= prev_entry.tag;
    end else if (ctrl.load_next) begin
      slot_tag <= next_entry.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      slot_dirty <= 1'b0;
    end else if (ctrl.load_prev) begin
      slot_valid <= prev_entry.valid;
      slot_dirty <= prev_entry.dirty;
    end else if (ctrl.load_next) begin
      slot_valid <= next_entry.valid;
      slot_dirty <= next_entry.dirty;
    end else if (ctrl.set_dirty) begin
      slot_dirty <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[design/cache_set_ordered_tag_store_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// ordered tag store for one cache set, first-in first-out replacement
// with a dirty bit per way
//
// s_* channel: one request item per handshake, the request kind in s_tuser
// m_* channel: exactly one result item per request
// cfg_* channel: writes ways_in_use, always ready; write it only while idle
//
// the ways sit in a row of cells, cell 0 newest; each cell compares its tag
// with the request and hands its entry to a neighbour when the row shifts
// (towards the tail on an add that misses, towards the head on an erase)
// the result is in the output register the cycle after acceptance
// throughput: one item per cycle while the receiver takes results; the cell row
// compares and shifts within the accepting cycle, which sets this
// a stalled receiver holds the result; s_tready stays high while the output
// register is empty or being emptied in the same cycle
// reset (rst, synchronous): all ways invalid and clean, ways_in_use = 8,
// no result pending

module cache_set_ordered_tag_store_top
  import csots_pkg::*;
#(
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WAYS_W-1:0] cfg_data,     // ways_in_use
  // requests
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,      // tag[31:0], dirty_in[32], zero fill
  input  logic [1:0]        s_tuser,      // req_type[1:0]
  // results
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,      // removed_dirty[0], removed_tag[32:1], zero fill
  output logic [1:0]        m_tuser       // hit[0], removed[1]
);

  localparam int LIM_W0 = $clog2(MAX_WAYS + 1);
  localparam int LIM_W  = (LIM_W0 > WAYS_W) ? LIM_W0 : WAYS_W;

  logic [WAYS_W-1:0] ways_in_use;
  logic [LIM_W-1:0]  ways_ext;
  logic [LIM_W-1:0]  limit;

  req_t             req;
  logic [TAG_W-1:0] req_tag;
  logic             req_dirty;
  logic             accept;

  entry_t           entries    [MAX_WAYS];
  entry_t           prev_ent   [MAX_WAYS];
  entry_t           next_ent   [MAX_WAYS];
  cell_ctrl_t       ctrl       [MAX_WAYS];
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] hit_before;
  logic [MAX_WAYS-1:0] hit_through;
  logic [MAX_WAYS-1:0] valid_vec;
  logic [MAX_WAYS-1:0] tail;
  logic [MAX_WAYS-1:0] evict_sel;
  logic [MAX_WAYS-1:0] rem_sel;

  logic             any_hit;
  logic             evict;
  logic             add_miss;
  logic             removed;
  logic             removed_dirty;
  logic [TAG_W-1:0] removed_tag;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= WAYS_RST;
    end else if (cfg_valid) begin
      ways_in_use <= cfg_data;
    end
  end

  // zero acts as one, anything above the way count as the way count
  assign ways_ext = LIM_W'(ways_in_use);
  always_comb begin
    if (ways_ext == '0) begin
      limit = LIM_W'(1);
    end else if (ways_ext > LIM_W'(MAX_WAYS)) begin
      limit = LIM_W'(MAX_WAYS);
    end else begin
      limit = ways_ext;
    end
  end

  // request fields
  assign req       = req_t'(s_tuser);
  assign req_tag   = s_tdata[TAG_W-1:0];
  assign req_dirty = s_tdata[TAG_W];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  assign any_hit  = hit_through[MAX_WAYS-1];
  assign add_miss = accept && (req == REQ_ADD) && !any_hit;
  // set is full when the way at position limit-1 is valid (ways form a prefix)
  assign evict    = |evict_sel;

  // row of cells
  for (genvar i = 0; i < MAX_WAYS; i++) begin : g_cell
    assign valid_vec[i] = entries[i].valid;
    assign evict_sel[i] = entries[i].valid && (limit == LIM_W'(i + 1));

    if (i == 0) begin : g_head
      assign hit_before[i] = 1'b0;
      assign prev_ent[i]   = '{tag: req_tag, dirty: req_dirty, valid: 1'b1};
    end else begin : g_body
      assign hit_before[i] = hit_through[i-1];
      assign prev_ent[i]   = entries[i-1];
    end

    if (i == MAX_WAYS - 1) begin : g_last
      assign next_ent[i] = '0;
      assign tail[i]     = entries[i].valid;
    end else begin : g_inner
      assign next_ent[i] = entries[i+1];
      assign tail[i]     = entries[i].valid && !entries[i+1].valid;
    end

    // add miss: shift towards the tail up to the new occupancy
    // erase hit: shift towards the head from the hit way onwards
    assign ctrl[i] = '{
      load_prev: add_miss && (evict ? entries[i].valid : prev_ent[i].valid),
      load_next: accept && (req == REQ_ERASE) && hit_through[i],
      set_dirty: accept && (req == REQ_MARK_DIRTY) && match[i] && !hit_before[i]
    };

    assign rem_sel[i] = ((req == REQ_ADD) && !any_hit && evict && tail[i]) ||
                        ((req == REQ_ERASE) && match[i] && !hit_before[i]);

    csots_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl[i]),
      .prev_entry  (prev_ent[i]),
      .next_entry  (next_ent[i]),
      .tag_in      (req_tag),
      .hit_before  (hit_before[i]),
      .entry       (entries[i]),
      .match       (match[i]),
      .hit_through (hit_through[i])
    );
  end

  // removed entry picked by a one-hot and-or select
  always_comb begin
    removed_dirty = 1'b0;
    removed_tag   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      removed_dirty = removed_dirty | (rem_sel[i] & entries[i].dirty);
      removed_tag   = removed_tag | (entries[i].tag & {TAG_W{rem_sel[i]}});
    end
  end
  assign removed = |rem_sel;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= {removed, any_hit};
      m_tdata <= {7'b0, removed_tag, removed_dirty};
    end
  end

  // ways always form a prefix of the row
  assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + (MAX_WAYS + 1)'(1)))
    else $error("valid ways do not form a prefix");

  // no removal means zero removed fields
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata == '0))
    else $error("removed fields set without a removal");

  // an add that misses lands in the head cell
  assert property (@(posedge clk) disable iff (rst)
    add_miss |=> (entries[0].valid && (entries[0].tag == $past(req_tag))))
    else $error("added tag not in head cell");

  // an erase that hits reports a removal
  assert property (@(posedge clk) disable iff (rst)
    (accept && (req == REQ_ERASE) && any_hit) |=> (m_tvalid && m_tuser[1] && m_tuser[0]))
    else $error("erase hit without removal");

endmodule

`default_nettype wire
